@@ src/bdpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

  // History keeps the low 13 bits; the top three bits are always one
  localparam int unsigned HIST_W = 13;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CIDX_W = 2;

  // 0xf000 and 0xe000 with the forced top bits removed
  localparam logic [HIST_W-1:0] HIST_TOP_ONE  = 13'h1000;
  localparam logic [HIST_W-1:0] HIST_ALL_ZERO = 13'h0000;
  localparam logic [CNT_W-1:0]  COUNT_MAX     = 16'hffff;

  // Register indexes on the configuration port
  localparam logic [CIDX_W-1:0] CFG_BACKLIGHT_SEC = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_DISPLAY_SEC   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_LONG_SAMPLES  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] BACKLIGHT_SEC_RST = 16'd30;
  localparam logic [CFG_W-1:0] DISPLAY_SEC_RST   = 16'd0;
  localparam logic [CFG_W-1:0] LONG_SAMPLES_RST  = 16'd200;

  typedef enum logic {
    ST_RELEASED,
    ST_PRESSED
  } press_state_t;

  typedef struct packed {
    logic sample_now;
    logic pin_level;
    logic second_tick;
  } in_item_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic held;
    logic display_on;
    logic backlight_on;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] backlight_seconds;
    logic [CFG_W-1:0] display_off_seconds;
    logic [CFG_W-1:0] long_press_samples;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/bdpc_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bdpc_in_if;
  logic valid;
  logic ready;
  logic sample_now;
  logic pin_level;
  logic second_tick;

  modport source (output valid, output sample_now, output pin_level, output second_tick,
                  input ready);
  modport sink (input valid, input sample_now, input pin_level, input second_tick,
                output ready);
endinterface

`default_nettype wire

@@ src/bdpc_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bdpc_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic held;
  logic display_on;
  logic backlight_on;

  modport source (output valid, output short_press, output long_press, output held,
                  output display_on, output backlight_on, input ready);
  modport sink (input valid, input short_press, input long_press, input held,
                input display_on, input backlight_on, output ready);
endinterface

`default_nettype wire

@@ src/bdpc_debounce.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdpc_debounce (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic                      sample_now,
  input  wire logic                      pin_level,
  output logic [bdpc_pkg::CNT_W-1:0]     count_nxt
);

  logic [bdpc_pkg::HIST_W-1:0] hist_r;
  logic [bdpc_pkg::HIST_W-1:0] hist_nxt;
  logic [bdpc_pkg::CNT_W-1:0]  count_r;
  logic                        stable;

  // Shift the pin in (high means pressed) and advance or clear the count
  always_comb begin
    hist_nxt  = hist_r;
    count_nxt = count_r;
    stable    = 1'b0;
    if (sample_now) begin
      hist_nxt = {hist_r[bdpc_pkg::HIST_W-2:0], ~pin_level};
      stable   = (hist_nxt == bdpc_pkg::HIST_TOP_ONE) ||
                 ((hist_nxt == bdpc_pkg::HIST_ALL_ZERO) && (count_r != '0));
      if (!stable) begin
        count_nxt = '0;
      end else if (count_r != bdpc_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      count_r <= '0;
    end else if (advance) begin
      hist_r  <= hist_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/bdpc_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdpc_fsm (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire logic                  second_tick,
  input  wire logic [bdpc_pkg::CNT_W-1:0] count,
  input  wire bdpc_pkg::cfg_t        cfg,
  output bdpc_pkg::result_t          result
);

  bdpc_pkg::press_state_t      state_r;
  bdpc_pkg::press_state_t      state_nxt;
  logic [bdpc_pkg::CNT_W-1:0]  last_r;
  logic [bdpc_pkg::CNT_W-1:0]  last_nxt;
  logic [bdpc_pkg::CNT_W-1:0]  sec_r;
  logic [bdpc_pkg::CNT_W-1:0]  sec_nxt;
  logic [bdpc_pkg::CNT_W-1:0]  sec_tick;
  logic                        long_rep_r;
  logic                        long_rep_nxt;
  logic                        disp_r;
  logic                        disp_nxt;
  logic                        bl_r;
  logic                        bl_nxt;
  logic                        short_p;
  logic                        long_p;

  // Count whole seconds, holding at full scale
  assign sec_tick = (second_tick && (sec_r != bdpc_pkg::COUNT_MAX)) ? sec_r + 1'b1 : sec_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdpc_pkg::ST_RELEASED: if (count != '0) state_nxt = bdpc_pkg::ST_PRESSED;
      bdpc_pkg::ST_PRESSED:  if (count == '0) state_nxt = bdpc_pkg::ST_RELEASED;
      default:               state_nxt = bdpc_pkg::ST_RELEASED;
    endcase
  end

  // Press pulses, timeouts and levels
  always_comb begin
    short_p      = 1'b0;
    long_p       = 1'b0;
    last_nxt     = last_r;
    long_rep_nxt = long_rep_r;
    sec_nxt      = sec_tick;
    disp_nxt     = disp_r;
    bl_nxt       = bl_r;
    unique case (state_r)
      bdpc_pkg::ST_RELEASED: begin
        if (count == '0) begin
          if (sec_tick >= cfg.backlight_seconds) bl_nxt = 1'b0;
          if ((cfg.display_off_seconds != '0) && (sec_tick >= cfg.display_off_seconds)) begin
            disp_nxt = 1'b0;
          end
        end
      end
      bdpc_pkg::ST_PRESSED: begin
        disp_nxt = 1'b1;
        if (cfg.backlight_seconds != '0) bl_nxt = 1'b1;
        if (count == '0) begin
          short_p      = (last_r < cfg.long_press_samples);
          long_rep_nxt = 1'b0;
          last_nxt     = '0;
          sec_nxt      = '0;
        end else begin
          last_nxt = count;
          if ((count >= cfg.long_press_samples) && !long_rep_r) begin
            long_rep_nxt = 1'b1;
            long_p       = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bdpc_pkg::ST_RELEASED;
      last_r     <= '0;
      sec_r      <= '0;
      long_rep_r <= 1'b0;
      disp_r     <= 1'b1;
      bl_r       <= 1'b1;
    end else if (advance) begin
      state_r    <= state_nxt;
      last_r     <= last_nxt;
      sec_r      <= sec_nxt;
      long_rep_r <= long_rep_nxt;
      disp_r     <= disp_nxt;
      bl_r       <= bl_nxt;
    end
  end

  assign result.short_press  = short_p;
  assign result.long_press   = long_p;
  assign result.held         = (state_nxt == bdpc_pkg::ST_PRESSED);
  assign result.display_on   = disp_nxt;
  assign result.backlight_on = bl_nxt;

  // A press is either short or long, never both
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(short_p && long_p)) else $error("short and long press on one transfer");

  // The long flag lives only inside a press
  a_long_in_press: assert property (@(posedge clk) disable iff (!rst_n)
    long_rep_r |-> (state_r == bdpc_pkg::ST_PRESSED)) else $error("long flag while released");

  // While released the stored press length is cleared
  a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdpc_pkg::ST_RELEASED) |-> (last_r == '0)) else $error("stale press length");

  // A release restarts the seconds count
  a_release_sec: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (state_r == bdpc_pkg::ST_PRESSED) && (count == '0)) |=> (sec_r == '0))
    else $error("seconds not cleared on release");

endmodule

`default_nettype wire

@@ src/button_debounce_press_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                                             Transfer
// in_ch     in    sample_now, pin_level, second_tick                  valid & ready
// out_ch    out   short_press, long_press, held, display_on,          valid & ready
//                 backlight_on
// cfg_*     in    cfg_index (2b), cfg_wdata (16b)                     cfg_we
//
// One item per clock while out_ch is not stalled; an accepted item passes through the
// input register and then the result register before it can transfer on out_ch.
// The press state, debounce history and timers update in the cycle an item moves
// from the input register to the result register.
// A stalled result holds in out_ch while one more item waits in the input register.
// rst_n is synchronous: state clears, registers take their defaults, display and
// backlight come up on.

module button_debounce_press_classifier (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bdpc_in_if.sink                           in_ch,
  bdpc_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [bdpc_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [bdpc_pkg::CFG_W-1:0]   cfg_wdata
);

  bdpc_pkg::cfg_t              cfg_r;
  bdpc_pkg::in_item_t          item_r;
  logic                        item_valid_r;
  bdpc_pkg::result_t           res_r;
  bdpc_pkg::result_t           res_nxt;
  logic                        out_valid_r;
  logic                        advance;
  logic [bdpc_pkg::CNT_W-1:0]  count_nxt;

  // Move the held item into the result register when that register is free
  assign advance      = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !item_valid_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backlight_seconds   <= bdpc_pkg::BACKLIGHT_SEC_RST;
      cfg_r.display_off_seconds <= bdpc_pkg::DISPLAY_SEC_RST;
      cfg_r.long_press_samples  <= bdpc_pkg::LONG_SAMPLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdpc_pkg::CFG_BACKLIGHT_SEC: cfg_r.backlight_seconds   <= cfg_wdata;
        bdpc_pkg::CFG_DISPLAY_SEC:   cfg_r.display_off_seconds <= cfg_wdata;
        bdpc_pkg::CFG_LONG_SAMPLES:  cfg_r.long_press_samples  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.sample_now  <= in_ch.sample_now;
      item_r.pin_level   <= in_ch.pin_level;
      item_r.second_tick <= in_ch.second_tick;
    end
  end

  bdpc_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .sample_now (item_r.sample_now),
    .pin_level  (item_r.pin_level),
    .count_nxt  (count_nxt)
  );

  bdpc_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .second_tick (item_r.second_tick),
    .count       (count_nxt),
    .cfg         (cfg_r),
    .result      (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.short_press  = res_r.short_press;
  assign out_ch.long_press   = res_r.long_press;
  assign out_ch.held         = res_r.held;
  assign out_ch.display_on   = res_r.display_on;
  assign out_ch.backlight_on = res_r.backlight_on;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  // Predicts the debouncer and press classifier, holds the outstanding results
  class press_scoreboard;
    logic [bdpc_pkg::HIST_W-1:0] hist;
    logic [bdpc_pkg::CNT_W-1:0]  press_cnt;
    logic [bdpc_pkg::CNT_W-1:0]  last_cnt;
    logic                        long_sent;
    bdpc_pkg::press_state_t      mode;
    logic [bdpc_pkg::CNT_W-1:0]  secs;
    logic                        disp_lvl;
    logic                        bl_lvl;
    logic [bdpc_pkg::CFG_W-1:0]  bl_secs;
    logic [bdpc_pkg::CFG_W-1:0]  disp_secs;
    logic [bdpc_pkg::CFG_W-1:0]  long_samples;
    bdpc_pkg::result_t           predicted_results[$];
    int unsigned                 errors;

    function new();
      hist         = '0;
      press_cnt    = '0;
      last_cnt     = '0;
      long_sent    = 1'b0;
      mode         = bdpc_pkg::ST_RELEASED;
      secs         = '0;
      disp_lvl     = 1'b1;
      bl_lvl       = 1'b1;
      bl_secs      = bdpc_pkg::BACKLIGHT_SEC_RST;
      disp_secs    = bdpc_pkg::DISPLAY_SEC_RST;
      long_samples = bdpc_pkg::LONG_SAMPLES_RST;
      errors       = 0;
    endfunction

    function void set_reg(logic [bdpc_pkg::CIDX_W-1:0] idx, logic [bdpc_pkg::CFG_W-1:0] val);
      case (idx)
        bdpc_pkg::CFG_BACKLIGHT_SEC: bl_secs = val;
        bdpc_pkg::CFG_DISPLAY_SEC:   disp_secs = val;
        bdpc_pkg::CFG_LONG_SAMPLES:  long_samples = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return predicted_results.size();
    endfunction

    // Advance the model by one accepted input and queue its result
    function void note_item(bdpc_pkg::in_item_t it);
      bdpc_pkg::result_t r;
      r = '0;
      if (it.second_tick && secs != bdpc_pkg::COUNT_MAX) secs++;
      // Shift the sample in; a high pin counts as pressed
      if (it.sample_now) begin
        hist = {hist[bdpc_pkg::HIST_W-2:0], ~it.pin_level};
        if (hist == bdpc_pkg::HIST_TOP_ONE ||
            (hist == bdpc_pkg::HIST_ALL_ZERO && press_cnt != '0)) begin
          if (press_cnt != bdpc_pkg::COUNT_MAX) press_cnt++;
        end else begin
          press_cnt = '0;
        end
      end
      if (mode == bdpc_pkg::ST_RELEASED) begin
        if (press_cnt != '0) begin
          mode = bdpc_pkg::ST_PRESSED;
        end else begin
          if (secs >= bl_secs) bl_lvl = 1'b0;
          if (disp_secs != '0 && secs >= disp_secs) disp_lvl = 1'b0;
        end
      end else begin
        disp_lvl = 1'b1;
        if (bl_secs != '0) bl_lvl = 1'b1;
        if (press_cnt == '0) begin
          if (last_cnt < long_samples) r.short_press = 1'b1;
          long_sent = 1'b0;
          last_cnt  = '0;
          mode      = bdpc_pkg::ST_RELEASED;
          secs      = '0;
        end else begin
          last_cnt = press_cnt;
          if (press_cnt >= long_samples && !long_sent) begin
            long_sent    = 1'b1;
            r.long_press = 1'b1;
          end
        end
      end
      r.held         = (mode == bdpc_pkg::ST_PRESSED);
      r.display_on   = disp_lvl;
      r.backlight_on = bl_lvl;
      predicted_results.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(bdpc_pkg::result_t got);
      bdpc_pkg::result_t exp_r;
      if (predicted_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        errors++;
        return;
      end
      exp_r = predicted_results.pop_front();
      if (got.short_press !== exp_r.short_press) begin
        $error("short_press: expected %0b actual %0b", exp_r.short_press, got.short_press);
        errors++;
      end
      if (got.long_press !== exp_r.long_press) begin
        $error("long_press: expected %0b actual %0b", exp_r.long_press, got.long_press);
        errors++;
      end
      if (got.held !== exp_r.held) begin
        $error("held: expected %0b actual %0b", exp_r.held, got.held);
        errors++;
      end
      if (got.display_on !== exp_r.display_on) begin
        $error("display_on: expected %0b actual %0b", exp_r.display_on, got.display_on);
        errors++;
      end
      if (got.backlight_on !== exp_r.backlight_on) begin
        $error("backlight_on: expected %0b actual %0b", exp_r.backlight_on,
               got.backlight_on);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [bdpc_pkg::CIDX_W-1:0] cfg_index;
  logic [bdpc_pkg::CFG_W-1:0]  cfg_wdata;

  bdpc_in_if  in_ch ();
  bdpc_out_if out_ch ();

  press_scoreboard sb;

  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_req;
  int unsigned items_sent;

  button_debounce_press_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Offer one item and hold it until the transfer
  task automatic send(input logic s, input logic p, input logic t);
    bdpc_pkg::in_item_t it;
    it.sample_now  = s;
    it.pin_level   = p;
    it.second_tick = t;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample_now  <= s;
    in_ch.pin_level   <= p;
    in_ch.second_tick <= t;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [bdpc_pkg::CFG_W-1:0] bl,
                              input logic [bdpc_pkg::CFG_W-1:0] ds,
                              input logic [bdpc_pkg::CFG_W-1:0] lp);
    logic [bdpc_pkg::CIDX_W-1:0] idx [3];
    logic [bdpc_pkg::CFG_W-1:0]  val [3];
    idx[0] = bdpc_pkg::CFG_BACKLIGHT_SEC;
    idx[1] = bdpc_pkg::CFG_DISPLAY_SEC;
    idx[2] = bdpc_pkg::CFG_LONG_SAMPLES;
    val[0] = bl;
    val[1] = ds;
    val[2] = lp;
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic rand_tick();
    return ($urandom_range(0, 3) == 0);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // One low sample, then k high samples; count reaches k-11, stray no-sample items mixed in
  task automatic press(input int unsigned k);
    send(1'b1, 1'b0, rand_tick());
    for (int unsigned i = 0; i < k; i++) begin
      if ($urandom_range(0, 7) == 0) send(1'b0, rand_bit(), rand_tick());
      send(1'b1, 1'b1, rand_tick());
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned target;
    int unsigned c;
    int unsigned r;
    stop_at = items_sent + n_items;
    target  = (sb.long_samples < 400) ? sb.long_samples : 30;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        // well-formed press, often near the long threshold
        if ($urandom_range(0, 2) == 0) c = target + $urandom_range(0, 4);
        else c = $urandom_range(1, 30);
        if (c > 2) c = c - 2;
        else c = 1;
        press(11 + c);
      end else if (r == 7) begin
        repeat ($urandom_range(1, 10)) send(rand_bit(), rand_bit(), rand_bit());
      end else if (r == 8) begin
        // bounce: too few high samples to count
        press($urandom_range(0, 11));
      end else begin
        repeat ($urandom_range(1, 15)) send(1'b0, rand_bit(), rand_bit());
      end
    end
  endtask

  // Result side: check transfers, stall in bursts, honor long hold-offs
  initial begin
    int unsigned rx_stall;
    int unsigned hold_left;
    bdpc_pkg::result_t got;
    rx_stall  = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.short_press  = out_ch.short_press;
        got.long_press   = out_ch.long_press;
        got.held         = out_ch.held;
        got.display_on   = out_ch.display_on;
        got.backlight_on = out_ch.backlight_on;
        sb.check_result(got);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample_now  = 1'b0;
    in_ch.pin_level   = 1'b1;
    in_ch.second_tick = 1'b0;
    tx_idle_on        = 1'b0;
    rx_idle_on        = 1'b0;
    hold_req          = 1'b0;
    items_sent        = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: backlight threshold zero turns it off on the very first released pass
    write_config(16'd0, bdpc_pkg::DISPLAY_SEC_RST, bdpc_pkg::LONG_SAMPLES_RST);
    send(1'b0, 1'b0, 1'b0);
    send(1'b0, 1'b1, 1'b1);
    press(12);
    send(1'b0, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b1);
    send(1'b1, 1'b1, 1'b0);
    send(1'b0, 1'b1, 1'b1);

    // Zero long threshold: long on the first pressed pass, never short
    write_config(16'd1, 16'd1, 16'd0);
    press(13);
    send(1'b1, 1'b0, 1'b1);
    send(1'b0, 1'b1, 1'b1);

    // Random phases over several settings
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_config(16'd3, 16'd5, 16'd4);
    hold_req = 1'b1;
    run_phase(130);

    write_config(16'hffff, 16'd0, 16'hffff);
    run_phase(110);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_config(16'd1, 16'd1, 16'd1);
    run_phase(60);
    drain();
    run_phase(60);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_config(16'd0, 16'd2, 16'd0);
    run_phase(110);

    write_config(16'd7, 16'hffff, 16'd200);
    run_phase(130);

    // Last part runs without idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                 16'($urandom_range(1, 25)));
    run_phase(110);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bdpc_pkg.sv
src/bdpc_in_if.sv
src/bdpc_out_if.sv
src/bdpc_debounce.sv
src/bdpc_fsm.sv
src/button_debounce_press_classifier.sv
tb/tb_top.sv
